// ===== sv/monte_carlo_convergence_monitor_unit_defines.svh =====
// assertion helpers for the convergence monitor
`ifndef MONTE_CARLO_CONVERGENCE_MONITOR_UNIT_DEFINES_SVH
`define MONTE_CARLO_CONVERGENCE_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MCCM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mccm assertion failed");

// next-cycle implication
`define MCCM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mccm assertion failed");

`endif

// ===== sv/mccm_pkg.sv =====
`default_nettype none
package mccm_pkg;

    localparam int SUM_W     = 40;
    localparam int SQ_W      = 56;
    localparam int ICNT_W    = 24;
    localparam int OUT_CNT_W = 24;
    localparam int WORK_W    = 64;
    localparam int PROD_W    = 96;
    localparam int INT_W     = 48;
    localparam int ERR_W     = 16;
    localparam int STAGE_W   = 4;

    // controller stages
    localparam logic [STAGE_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STAGE_W-1:0] ST_DIV_MEAN = 4'd1;
    localparam logic [STAGE_W-1:0] ST_DIV_MSQ  = 4'd2;
    localparam logic [STAGE_W-1:0] ST_MUL_SQ   = 4'd3;
    localparam logic [STAGE_W-1:0] ST_DIV_VAR  = 4'd4;
    localparam logic [STAGE_W-1:0] ST_SQRT     = 4'd5;
    localparam logic [STAGE_W-1:0] ST_MUL_ERR  = 4'd6;
    localparam logic [STAGE_W-1:0] ST_DIV_ERR  = 4'd7;
    localparam logic [STAGE_W-1:0] ST_MUL_INT  = 4'd8;
    localparam logic [STAGE_W-1:0] ST_REPORT   = 4'd9;

    // report status codes
    localparam logic [1:0] STAT_RUNNING   = 2'd0;
    localparam logic [1:0] STAT_CONVERGED = 2'd1;
    localparam logic [1:0] STAT_ZERO      = 2'd2;
    localparam logic [1:0] STAT_GAVE_UP   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_VOLUME    = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_MAX_EVALS = 2'd2;
    localparam logic [1:0] REG_MAX_ERR   = 2'd3;

    // 100 percent times 2^8 (Q8.8) times 2^4 (root is Q.12 against mean Q.16)
    localparam logic [WORK_W-1:0] ERR_FACTOR = 64'd409600;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic               accept;
        logic               start;
        logic               capture;
        logic               report;
    } mccm_cmd_t;

    typedef struct packed {
        logic check_req;
        logic unit_done;
        logic out_busy;
    } mccm_stat_t;

endpackage
`default_nettype wire

// ===== sv/mccm_div.sv =====
`default_nettype none
module mccm_div
    import mccm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORK_W-1:0] dividend,
    input  wire logic [WORK_W-1:0] divisor,
    output logic      [WORK_W-1:0] quotient,
    output logic                   done
);

    logic [WORK_W-1:0] quo_reg, quo_next;
    logic [WORK_W-1:0] rem_reg, rem_next;
    logic [WORK_W-1:0] dvs_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORK_W:0]   trial;
    logic [WORK_W:0]   diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[WORK_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[WORK_W])
        begin
            rem_next = diff[WORK_W-1:0];
            quo_next = {quo_reg[WORK_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[WORK_W-1:0];
            quo_next = {quo_reg[WORK_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

// ===== sv/mccm_mul.sv =====
`default_nettype none
module mccm_mul
    import mccm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORK_W-1:0] mcand,
    input  wire logic [WORK_W-1:0] mplier,
    output logic      [PROD_W-1:0] product,
    output logic                   done
);

    logic [PROD_W-1:0] mcand_reg;
    logic [WORK_W-1:0] mplier_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    // shift and add, one multiplier bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= PROD_W'(mcand);
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[WORK_W-1:1]};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule
`default_nettype wire

// ===== sv/mccm_ctrl.sv =====
`default_nettype none
module mccm_ctrl
    import mccm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire mccm_stat_t stat,
    output mccm_cmd_t       cmd
);

    logic [STAGE_W-1:0] state_reg, state_next;
    logic               go_reg, go_next;
    logic               report;

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        report     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.check_req)
                begin
                    state_next = ST_DIV_MEAN;
                    go_next    = 1'b1;
                end
            end
            ST_DIV_MEAN, ST_DIV_MSQ, ST_MUL_SQ, ST_DIV_VAR,
            ST_SQRT, ST_MUL_ERR, ST_DIV_ERR:
            begin
                if (stat.unit_done)
                begin
                    state_next = state_reg + STAGE_W'(1);
                    go_next    = 1'b1;
                end
            end
            ST_MUL_INT:
            begin
                if (stat.unit_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                // wait until the output register is free
                if (!stat.out_busy)
                begin
                    report     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE) || stat.check_req;
    assign cmd.stage   = state_reg;
    assign cmd.accept  = in_valid && !in_stall;
    assign cmd.start   = go_reg;
    assign cmd.capture = stat.unit_done;
    assign cmd.report  = report;

endmodule
`default_nettype wire

// ===== sv/mccm_dp.sv =====
`default_nettype none
module mccm_dp
    import mccm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 24
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mccm_cmd_t                      cmd,
    output mccm_stat_t                          stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  wire logic                           cfg_we,
    input  wire logic        [1:0]              cfg_index,
    input  wire logic        [31:0]             cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic             [1:0]              status,
    output logic signed      [INT_W-1:0]        integral,
    output logic             [ERR_W-1:0]        error_pct,
    output logic             [OUT_CNT_W-1:0]    sample_count
);

    // configuration
    logic [31:0]        volume_reg;
    logic [ICNT_W-1:0]  interval_reg;
    logic [23:0]        max_evals_reg;
    logic [ERR_W-1:0]   max_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg    <= 32'd65536;
            interval_reg  <= 24'd1000;
            max_evals_reg <= 24'd1000000;
            max_err_reg   <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VOLUME:    volume_reg    <= cfg_data;
                REG_INTERVAL:  interval_reg  <= cfg_data[23:0];
                REG_MAX_EVALS: max_evals_reg <= cfg_data[23:0];
                REG_MAX_ERR:   max_err_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // accumulators
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]          vsum_reg, vsum_next;
    logic [SQ_W-1:0]           ssum_reg, ssum_next;
    logic [ICNT_W-1:0]         icnt_reg, icnt_next;
    logic                      check_reg;
    logic signed [SUM_W-1:0]   s_ext;
    logic [SAMPLE_WIDTH:0]     s_neg;
    logic [SAMPLE_WIDTH-1:0]   smag;
    logic [2*SAMPLE_WIDTH-1:0] sq;
    logic [ICNT_W-1:0]         interval;
    logic                      sat_next;
    logic                      out_valid_reg;
    logic [1:0]                status_now;

    assign s_ext      = SUM_W'(sample_value);
    assign s_neg      = -{sample_value[SAMPLE_WIDTH-1], sample_value};
    assign smag       = sample_value[SAMPLE_WIDTH-1] ? s_neg[SAMPLE_WIDTH-1:0] : sample_value;
    assign sq         = smag * smag;
    assign vsum_next  = vsum_reg + s_ext;
    assign ssum_next  = ssum_reg + SQ_W'(sq);
    assign count_next = count_reg + COUNT_WIDTH'(1);
    assign icnt_next  = icnt_reg + ICNT_W'(1);
    assign interval   = (interval_reg == '0) ? ICNT_W'(1) : interval_reg;
    assign sat_next   = (count_next == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            vsum_reg  <= '0;
            ssum_reg  <= '0;
            icnt_reg  <= '0;
            check_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            count_reg <= count_next;
            vsum_reg  <= vsum_next;
            ssum_reg  <= ssum_next;
            icnt_reg  <= icnt_next;
            check_reg <= sat_next || !(icnt_next < interval);
        end
        else if (cmd.report)
        begin
            check_reg <= 1'b0;
            icnt_reg  <= '0;
            if (status_now != STAT_RUNNING)
            begin
                count_reg <= '0;
                vsum_reg  <= '0;
                ssum_reg  <= '0;
            end
        end
    end

    // check arithmetic
    logic              neg;
    logic [SUM_W-1:0]  smag_sum;
    logic [WORK_W-1:0] n;
    logic [WORK_W-1:0] mean_reg;
    logic [WORK_W-1:0] work_reg;
    logic [31:0]       root_reg;
    logic [ERR_W-1:0]  err_reg;
    logic [INT_W-1:0]  int_reg;
    logic [WORK_W-1:0] div_a, div_b, div_q;
    logic [WORK_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              div_start, mul_start, sqrt_start;
    logic              div_done, mul_done, sqrt_done;
    logic [WORK_W-1:0] m2;
    logic [INT_W-1:0]  imag;
    logic [INT_W-1:0]  int_val;

    assign neg      = vsum_reg[SUM_W-1];
    assign smag_sum = neg ? (SUM_W'(0) - vsum_reg) : vsum_reg;
    assign n        = (count_reg == '0) ? WORK_W'(1) : WORK_W'(count_reg);

    assign div_start = cmd.start && ((cmd.stage == ST_DIV_MEAN) || (cmd.stage == ST_DIV_MSQ)
                       || (cmd.stage == ST_DIV_VAR) || (cmd.stage == ST_DIV_ERR));
    assign mul_start = cmd.start && ((cmd.stage == ST_MUL_SQ) || (cmd.stage == ST_MUL_ERR)
                       || (cmd.stage == ST_MUL_INT));
    assign sqrt_start = cmd.start && (cmd.stage == ST_SQRT);

    always_comb
    begin
        div_a = work_reg;
        div_b = n;
        mul_a = mean_reg;
        mul_b = mean_reg;
        unique case (cmd.stage)
            ST_DIV_MEAN: div_a = WORK_W'({smag_sum, 16'd0});
            ST_DIV_MSQ:  div_a = {ssum_reg, 8'd0};
            ST_DIV_VAR:  div_a = {work_reg[WORK_W-17:0], 16'd0};
            ST_DIV_ERR:  div_b = mean_reg;
            ST_MUL_ERR:
            begin
                mul_a = WORK_W'(root_reg);
                mul_b = ERR_FACTOR;
            end
            ST_MUL_INT:  mul_b = WORK_W'(volume_reg);
            default:     ;
        endcase
    end

    mccm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    mccm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    // integer square root, two radicand bits a cycle
    logic [WORK_W-1:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [WORK_W-1:0] sq_trial;
    logic [4:0]        sq_cnt_reg;
    logic              sq_busy_reg, sq_done_reg;

    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= sq_busy_reg && (sq_cnt_reg == 5'd31);
            if (sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'd31)
                    sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sqrt_start)
        begin
            sq_v_reg   <= work_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= WORK_W'(1) << (WORK_W - 2);
        end
        else if (sq_busy_reg)
        begin
            if (sq_v_reg >= sq_trial)
            begin
                sq_v_reg   <= sq_v_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    assign sqrt_done = sq_done_reg;

    assign m2 = WORK_W'(mul_p[WORK_W-1:24]);

    // product wider than 64 bits saturates like the overflow guard
    always_comb
    begin
        if (mul_p[PROD_W-1:WORK_W] != '0)
            imag = '1;
        else
            imag = mul_p[WORK_W-1:16];
        if (neg)
        begin
            if (imag > {1'b1, {(INT_W-1){1'b0}}})
                int_val = {1'b1, {(INT_W-1){1'b0}}};
            else
                int_val = INT_W'(0) - imag;
        end
        else
        begin
            if (imag[INT_W-1])
                int_val = {1'b0, {(INT_W-1){1'b1}}};
            else
                int_val = imag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            unique case (cmd.stage)
                ST_DIV_MEAN: mean_reg <= div_q;
                ST_DIV_MSQ:  work_reg <= div_q;
                ST_MUL_SQ:   work_reg <= (work_reg > m2) ? (work_reg - m2) : '0;
                ST_DIV_VAR:  work_reg <= div_q;
                ST_SQRT:     root_reg <= sq_res_reg[31:0];
                ST_MUL_ERR:  work_reg <= mul_p[WORK_W-1:0];
                ST_DIV_ERR:
                begin
                    if (mean_reg == '0)
                        err_reg <= '0;
                    else if (div_q[WORK_W-1:ERR_W] != '0)
                        err_reg <= '1;
                    else
                        err_reg <= div_q[ERR_W-1:0];
                end
                ST_MUL_INT:  int_reg <= int_val;
                default:     ;
            endcase
        end
    end

    // report decision, zero first, then gave up, then converged
    always_comb
    begin
        priority if (int_reg == '0)
            status_now = STAT_ZERO;
        else if ((24'(count_reg) > max_evals_reg) || (count_reg == '1))
            status_now = STAT_GAVE_UP;
        else if (err_reg < max_err_reg)
            status_now = STAT_CONVERGED;
        else
            status_now = STAT_RUNNING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.report)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            status       <= status_now;
            integral     <= int_reg;
            error_pct    <= err_reg;
            sample_count <= OUT_CNT_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.check_req = check_reg;
    assign stat.unit_done = div_done || mul_done || sqrt_done;
    assign stat.out_busy  = out_valid_reg && out_stall;

endmodule
`default_nettype wire

// ===== sv/monte_carlo_convergence_monitor_unit.sv =====
`default_nettype none
// channel   signals                                         direction
// input     in_valid, in_stall, sample_value                samples in
// output    out_valid, out_stall, status, integral,         reports out
//           error_pct, sample_count
// config    cfg_we, cfg_index, cfg_data                     register writes
//
// samples that do not reach a check point are taken back to back
// a check runs a bit-serial divider four times, a shift-add multiplier three times
// and a bit-serial square root, and no sample is taken while the check runs
// reset clears the sums and counters and loads the register defaults
// a report waits in the output register while out_stall is high; sampling goes on,
// and the next check runs but holds its report until the output register is free
`include "monte_carlo_convergence_monitor_unit_defines.svh"
module monte_carlo_convergence_monitor_unit
    import mccm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 24
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic             [1:0]              status,
    output logic signed      [INT_W-1:0]        integral,
    output logic             [ERR_W-1:0]        error_pct,
    output logic             [OUT_CNT_W-1:0]    sample_count,
    input  wire logic                           cfg_we,
    input  wire logic        [1:0]              cfg_index,
    input  wire logic        [31:0]             cfg_data
);

    mccm_cmd_t  cmd;
    mccm_stat_t stat;

    mccm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mccm_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample_value (sample_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .integral     (integral),
        .error_pct    (error_pct),
        .sample_count (sample_count)
    );

    `MCCM_ASSERT_IMP(a_report_free, cmd.report, !(out_valid && out_stall))
    `MCCM_ASSERT_NEXT(a_report_shown, cmd.report, out_valid)
    `MCCM_ASSERT_IMP(a_done_in_stage, stat.unit_done,
                     (cmd.stage != ST_IDLE) && (cmd.stage != ST_REPORT))

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
module testbench;
    import mccm_pkg::*;

    typedef struct packed {
        logic [1:0]  stat;
        logic [47:0] integ;
        logic [15:0] err;
        logic [23:0] cnt;
    } report_t;

    localparam int SETTLE_CYCLES = 700;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] sample_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [47:0] integral;
    logic [15:0]        error_pct;
    logic [23:0]        sample_count;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    // model copy of registers and accumulators
    logic [31:0] volume_reg;
    logic [23:0] interval_reg;
    logic [23:0] max_evals_reg;
    logic [15:0] max_err_reg;
    logic [23:0] acc_count;
    logic [39:0] acc_sum;
    logic [55:0] acc_squares;
    logic [23:0] acc_interval;

    report_t pending_reports[$];
    int      mismatches;
    int      samples_sent;
    int      reports_seen;
    int      status_seen[4];
    int      long_hold;
    bit      steady;

    monte_carlo_convergence_monitor_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .integral(integral), .error_pct(error_pct), .sample_count(sample_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit [63:0] int_sqrt(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void clear_accumulators();
        acc_count = 0;
        acc_sum = 0;
        acc_squares = 0;
        acc_interval = 0;
    endfunction

    // accumulate one sample and queue the report it triggers, if any
    function automatic void accumulate_sample(input logic signed [15:0] smp);
        longint    s;
        bit [63:0] smag, ivl, n, smag_sum, mean, msq, m2, var_q, var_n, root, err, imag;
        bit [47:0] integ;
        logic signed [39:0] sum_s;
        bit        sat, neg;
        report_t   r;
        s = smp;
        smag = (s < 0) ? -s : s;
        ivl = (interval_reg == 0) ? 64'd1 : 64'(interval_reg);
        acc_sum = acc_sum + 40'(s);
        acc_squares = acc_squares + 56'(smag * smag);
        acc_count = acc_count + 24'd1;
        acc_interval = acc_interval + 24'd1;
        sat = (acc_count == 24'hffffff);
        if (!sat && acc_interval < ivl)
            return;
        n = (acc_count == 0) ? 64'd1 : 64'(acc_count);
        sum_s = acc_sum;
        neg = sum_s < 0;
        smag_sum = neg ? 64'(-longint'(sum_s)) : 64'(longint'(sum_s));
        mean = (smag_sum << 16) / n;
        msq = ({8'd0, acc_squares} << 8) / n;
        m2 = (mean * mean) >> 24;
        var_q = (msq > m2) ? msq - m2 : 0;
        var_n = (var_q << 16) / n;
        root = int_sqrt(var_n);
        err = 0;
        if (mean != 0)
        begin
            err = (root * 64'd409600) / mean;
            if (err > 65535)
                err = 65535;
        end
        if (mean != 0 && 64'(volume_reg) > ~64'd0 / mean)
            imag = ~64'd0 >> 16;
        else
            imag = (mean * volume_reg) >> 16;
        if (neg)
        begin
            if (imag > (64'd1 << 47))
                imag = 64'd1 << 47;
            integ = 48'(-imag);
        end
        else
        begin
            if (imag > (64'd1 << 47) - 1)
                imag = (64'd1 << 47) - 1;
            integ = imag[47:0];
        end
        if (integ == 0)
            r.stat = STAT_ZERO;
        else if (acc_count > max_evals_reg || sat)
            r.stat = STAT_GAVE_UP;
        else if (err < max_err_reg)
            r.stat = STAT_CONVERGED;
        else
            r.stat = STAT_RUNNING;
        r.integ = integ;
        r.err = err[15:0];
        r.cnt = acc_count;
        pending_reports.push_back(r);
        if (r.stat != STAT_RUNNING)
            clear_accumulators();
        else
            acc_interval = 0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns at the edge where the item was taken
    task automatic send_sample(input logic signed [15:0] v);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= v;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        accumulate_sample(v);
        samples_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VOLUME:    volume_reg = data;
            REG_INTERVAL:  interval_reg = data[23:0];
            REG_MAX_EVALS: max_evals_reg = data[23:0];
            REG_MAX_ERR:   max_err_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] vol, input logic [23:0] ivl,
                           input logic [23:0] mev, input logic [15:0] merr);
        wait_idle();
        write_reg(REG_VOLUME, vol);
        write_reg(REG_INTERVAL, {8'd0, ivl});
        write_reg(REG_MAX_EVALS, {8'd0, mev});
        write_reg(REG_MAX_ERR, {16'd0, merr});
    endtask

    // report checker
    initial
    begin
        report_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                reports_seen++;
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report: status %0d integral %0d", status,
                                 integral);
                end
                else
                begin
                    exp_r = pending_reports.pop_front();
                    status_seen[exp_r.stat]++;
                    if (status !== exp_r.stat || integral !== exp_r.integ ||
                        error_pct !== exp_r.err || sample_count !== exp_r.cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st %0d int %0h err %0d cnt %0d,",
                                      " got st %0d int %0h err %0d cnt %0d"},
                                     exp_r.stat, exp_r.integ, exp_r.err, exp_r.cnt,
                                     status, integral, error_pct, sample_count);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int  left;
        int  r;
        bit  st;
        left = 0;
        st = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                out_stall <= 1'b1;
                long_hold--;
            end
            else
            begin
                if (left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (steady)
                    begin
                        st = 0;
                        left = 50;
                    end
                    else if (r < 50)
                    begin
                        st = 0;
                        left = $urandom_range(1, 20);
                    end
                    else if (r < 90)
                    begin
                        st = 1;
                        left = $urandom_range(1, 4);
                    end
                    else
                    begin
                        st = 1;
                        left = $urandom_range(20, 120);
                    end
                end
                out_stall <= st;
                left--;
            end
        end
    end

    task automatic test_sample_extremes();
        set_all(32'd65536, 24'd1, 24'd1000000, 16'hffff);
        send_sample(16'sh7fff);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
    endtask

    task automatic test_volume_extremes();
        // largest volume brings the integral close to saturation both ways
        set_all(32'hffffffff, 24'd1, 24'd1000000, 16'd256);
        send_sample(16'sh7fff);
        send_sample(-16'sd32768);
        set_all(32'd0, 24'd2, 24'd1000000, 16'd256);
        send_sample(16'sd300);
        send_sample(-16'sd77);
    endtask

    task automatic test_zero_mean_and_running();
        // zero mean, then max error 0 keeps status running across checks
        set_all(32'd131072, 24'd2, 24'hffffff, 16'd0);
        send_sample(16'sd500);
        send_sample(-16'sd500);
        send_sample(16'sd900);
        send_sample(16'sd100);
        send_sample(16'sd256);
        send_sample(-16'sd40);
    endtask

    task automatic test_gave_up();
        // zero max_evaluations, then count passing the limit
        set_all(32'd65536, 24'd2, 24'd0, 16'd256);
        send_sample(16'sd10);
        send_sample(16'sd20);
        set_all(32'd65536, 24'd2, 24'd3, 16'd0);
        repeat (4) send_sample(16'sd700);
    endtask

    task automatic test_interval_changes();
        // interval dropped below progress, then interval zero
        set_all(32'd65536, 24'hffffff, 24'd1000000, 16'd256);
        repeat (3) send_sample(16'sd1000);
        wait_idle();
        write_reg(REG_INTERVAL, 32'd2);
        send_sample(16'sd1001);
        wait_idle();
        write_reg(REG_INTERVAL, 32'd0);
        send_sample(16'sd50);
        send_sample(-16'sd60);
    endtask

    task automatic test_output_backpressure();
        set_all(32'd65536, 24'd1, 24'd1000000, 16'd256);
        wait_idle();
        long_hold = 4000;
        repeat (8) send_sample(16'($urandom));
    endtask

    task automatic test_random_phases();
        int phase;
        int r;
        int center;
        int spread;
        logic [31:0] vol;
        for (phase = 0; phase < 12; phase++)
        begin
            r = $urandom_range(0, 9);
            vol = (r == 0) ? 32'd0 : (r == 1) ? 32'hffffffff : $urandom_range(1, 32'h00400000);
            set_all(vol,
                    24'((phase % 4 == 0) ? $urandom_range(0, 3) : $urandom_range(1, 16)),
                    24'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 24'hffffff),
                    16'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2048)));
            steady = (phase % 5 == 2);
            repeat (20)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    // noisy samples around a center, the normal use
                    center = $signed(16'($urandom));
                    spread = 1 << $urandom_range(0, 10);
                    repeat ($urandom_range(1, 12))
                        send_sample(16'($signed(center) +
                                    $signed($urandom_range(0, 2 * spread)) - spread));
                end
                else
                    send_sample(16'($urandom));
            end
            steady = 0;
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        sample_value = 0;
        out_stall = 0;
        cfg_we = 0;
        cfg_index = REG_VOLUME;
        cfg_data = 0;
        mismatches = 0;
        samples_sent = 0;
        reports_seen = 0;
        long_hold = 0;
        steady = 0;
        volume_reg = 32'd65536;
        interval_reg = 24'd1000;
        max_evals_reg = 24'd1000000;
        max_err_reg = 16'd256;
        clear_accumulators();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sample_extremes();
        test_volume_extremes();
        test_zero_mean_and_running();
        test_gave_up();
        test_interval_changes();
        test_output_backpressure();
        test_random_phases();
        wait_idle();
        $display("run covered %0d samples and %0d reports", samples_sent, reports_seen);
        $display("statuses running %0d converged %0d zero %0d gave up %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(12 * 4000000);
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
